>>> rtl/core/svp_pkg.sv
// ---------------------------------------------------------------------------
// svp_pkg: shared types and constants of the servo pulse sequencer
// register map, reset values, request structs and the per-channel slew step
// ---------------------------------------------------------------------------
package svp_pkg;

  localparam int unsigned DefChannels = 6;
  localparam int unsigned WidthW      = 16;
  localparam int unsigned RampW       = 12;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned ApbAddrW    = 5;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [WidthW-1:0] RstSlotTicks  = 16'd5000;
  localparam logic [WidthW-1:0] RstFrameTicks = 16'd40000;
  localparam logic [RampW-1:0]  RstRampStep   = 12'd75;
  localparam logic [WidthW-1:0] RstMinWidth   = 16'd1000;
  localparam logic [WidthW-1:0] RstMaxWidth   = 16'd5000;
  localparam logic [WidthW-1:0] RstWidth      = 16'd3000;

  typedef enum logic [2:0] {
    REG_SLOT_TICKS  = 3'd0,
    REG_FRAME_TICKS = 3'd1,
    REG_RAMP_STEP   = 3'd2,
    REG_MIN_WIDTH   = 3'd3,
    REG_MAX_WIDTH   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_TICK       = 1'b0,
    KIND_SET_TARGET = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WidthW-1:0] slot_ticks;
    logic [WidthW-1:0] frame_ticks;
    logic [RampW-1:0]  ramp_step;
    logic [WidthW-1:0] min_width;
    logic [WidthW-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [ChanW-1:0]  channel;
    logic [WidthW-1:0] target_width;
  } item_t;

  // a zero length counts as one tick
  function automatic logic [WidthW-1:0] eff_len(input logic [WidthW-1:0] v);
    eff_len = (v == '0) ? WidthW'(1) : v;
  endfunction

  // move one width toward its target by at most step, landing on target
  function automatic logic [WidthW-1:0] slew_one(input logic [WidthW-1:0] cur,
                                                 input logic [WidthW-1:0] tgt,
                                                 input logic [RampW-1:0]  step);
    logic [WidthW-1:0] step_w;
    step_w = WidthW'(step);
    if (cur < tgt) begin
      slew_one = ((tgt - cur) > step_w) ? cur + step_w : tgt;
    end else if (cur > tgt) begin
      slew_one = ((cur - tgt) > step_w) ? cur - step_w : tgt;
    end else begin
      slew_one = cur;
    end
  endfunction

endpackage

>>> rtl/core/svp_in_stage.sv
// ---------------------------------------------------------------------------
// svp_in_stage: input register of the sequencer
// holds one request and frees itself whenever the engine takes it
// ---------------------------------------------------------------------------
module svp_in_stage import svp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

>>> rtl/core/svp_engine.sv
// ---------------------------------------------------------------------------
// svp_engine: width state, frame counters and result register
// applies one registered request per cycle unless stalled, registers its result
// ---------------------------------------------------------------------------
module svp_engine import svp_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                take_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output logic [CHANNELS-1:0] pulse_lines_o,
  output logic                frame_start_o,
  output logic                all_settled_o
);

  localparam int unsigned StageW = $clog2(CHANNELS + 1);

  logic [WidthW-1:0] cur_q [CHANNELS];
  logic [WidthW-1:0] cur_d [CHANNELS];
  logic [WidthW-1:0] tgt_q [CHANNELS];
  logic [WidthW-1:0] tgt_d [CHANNELS];
  logic [WidthW-1:0] slewed [CHANNELS];

  logic [WidthW-1:0] frame_cnt_q, frame_cnt_d;
  logic [StageW-1:0] stage_q, stage_d;
  logic [WidthW-1:0] stage_cnt_q, stage_cnt_d;
  logic [WidthW-1:0] latched_q, latched_d;

  logic                res_valid_q;
  logic [CHANNELS-1:0] lines_q, lines_d;
  logic                fstart_q, fstart_d;
  logic                settled_q, settled_d;

  logic              adv;
  logic              fire;
  logic [WidthW-1:0] clamped;
  logic [StageW-1:0] stage_now;
  logic [WidthW-1:0] stage_cnt_now;
  logic [WidthW-1:0] latched_now;
  logic [WidthW:0]   stage_cnt_inc;
  logic [WidthW:0]   frame_cnt_inc;

  assign adv    = !res_valid_q || res_ready_i;
  assign fire   = item_valid_i && adv;
  assign take_o = fire;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      slewed[c] = slew_one(cur_q[c], tgt_q[c], cfg_i.ramp_step);
    end
  end

  // clamp: minimum first, then maximum wins
  always_comb begin
    clamped = item_i.target_width;
    if (clamped < cfg_i.min_width) begin
      clamped = cfg_i.min_width;
    end
    if (clamped > cfg_i.max_width) begin
      clamped = cfg_i.max_width;
    end
  end

  always_comb begin
    cur_d         = cur_q;
    tgt_d         = tgt_q;
    frame_cnt_d   = frame_cnt_q;
    stage_d       = stage_q;
    stage_cnt_d   = stage_cnt_q;
    latched_d     = latched_q;
    lines_d       = '0;
    fstart_d      = 1'b0;
    stage_now     = stage_q;
    stage_cnt_now = stage_cnt_q;
    latched_now   = latched_q;
    stage_cnt_inc = '0;
    frame_cnt_inc = '0;
    if (item_i.kind == KIND_SET_TARGET) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (int'(item_i.channel) == c) begin
          tgt_d[c] = clamped;
        end
      end
    end else begin
      if (frame_cnt_q == '0) begin
        fstart_d      = 1'b1;
        cur_d         = slewed;
        stage_now     = '0;
        stage_cnt_now = '0;
        latched_now   = slewed[0];
      end
      stage_d     = stage_now;
      stage_cnt_d = stage_cnt_now;
      latched_d   = latched_now;
      if ((stage_now < StageW'(CHANNELS)) && (stage_cnt_now < latched_now)) begin
        lines_d = CHANNELS'(1) << stage_now;
      end
      if (stage_now < StageW'(CHANNELS)) begin
        stage_cnt_inc = {1'b0, stage_cnt_now} + (WidthW+1)'(1);
        if (stage_cnt_inc >= {1'b0, eff_len(cfg_i.slot_ticks)}) begin
          stage_d     = stage_now + StageW'(1);
          stage_cnt_d = '0;
          latched_d   = '0;
          for (int c = 0; c < CHANNELS; c++) begin
            if (int'(stage_d) == c) begin
              latched_d = cur_d[c];
            end
          end
        end else begin
          stage_cnt_d = stage_cnt_inc[WidthW-1:0];
        end
      end
      frame_cnt_inc = {1'b0, frame_cnt_q} + (WidthW+1)'(1);
      if (frame_cnt_inc >= {1'b0, eff_len(cfg_i.frame_ticks)}) begin
        frame_cnt_d = '0;
      end else begin
        frame_cnt_d = frame_cnt_inc[WidthW-1:0];
      end
    end
    settled_d = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cur_d[c] != tgt_d[c]) begin
        settled_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cur_q[c] <= RstWidth;
        tgt_q[c] <= RstWidth;
      end
      frame_cnt_q <= '0;
      stage_q     <= '0;
      stage_cnt_q <= '0;
      latched_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cur_q       <= cur_d;
        tgt_q       <= tgt_d;
        frame_cnt_q <= frame_cnt_d;
        stage_q     <= stage_d;
        stage_cnt_q <= stage_cnt_d;
        latched_q   <= latched_d;
      end
      if (adv) begin
        res_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      lines_q   <= lines_d;
      fstart_q  <= fstart_d;
      settled_q <= settled_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign pulse_lines_o = lines_q;
  assign frame_start_o = fstart_q;
  assign all_settled_o = settled_q;

endmodule

>>> rtl/core/servo_pulse_sequencer_with_slew.sv
// ---------------------------------------------------------------------------
// servo_pulse_sequencer_with_slew: multi-channel servo pulse sequencer
// one tick or target-write request in, one pulse-line result out
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         tick or target write (tuser kind, tdata channel/width)
//  m_axis    out        pulse lines, frame start, all settled
//  apb       in/out     timing, ramp step and clamp limits
//
//  a request waits in the input register; the engine works on it there and
//  loads the result register; one request per cycle is sustained while results
//  are taken, the rate being set by the single pass through the engine (slew,
//  counters and settle compare in one stage)
//  reset: widths and targets 3000, counters zero, registers to defaults
//  a stalled result holds the engine; the input register still takes one more
// ---------------------------------------------------------------------------
module servo_pulse_sequencer_with_slew import svp_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels,
  localparam int unsigned OutW    = ((CHANNELS + 2 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // streaming request side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [2:0] channel, [18:3] target_width
  input  logic                s_axis_tuser,   // [0] kind
  // streaming result side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,   // pulse_lines, frame_start, all_settled
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  item_t               in_item;
  item_t               item;
  logic                item_valid;
  logic                take;
  logic [CHANNELS-1:0] pulse_lines;
  logic                frame_start;
  logic                all_settled;

  // ---- configuration registers, word addressed
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_ticks  <= RstSlotTicks;
      cfg_q.frame_ticks <= RstFrameTicks;
      cfg_q.ramp_step   <= RstRampStep;
      cfg_q.min_width   <= RstMinWidth;
      cfg_q.max_width   <= RstMaxWidth;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SLOT_TICKS:  cfg_q.slot_ticks  <= pwdata[WidthW-1:0];
        REG_FRAME_TICKS: cfg_q.frame_ticks <= pwdata[WidthW-1:0];
        REG_RAMP_STEP:   cfg_q.ramp_step   <= pwdata[RampW-1:0];
        REG_MIN_WIDTH:   cfg_q.min_width   <= pwdata[WidthW-1:0];
        REG_MAX_WIDTH:   cfg_q.max_width   <= pwdata[WidthW-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOT_TICKS:  prdata = ApbDataW'(cfg_q.slot_ticks);
      REG_FRAME_TICKS: prdata = ApbDataW'(cfg_q.frame_ticks);
      REG_RAMP_STEP:   prdata = ApbDataW'(cfg_q.ramp_step);
      REG_MIN_WIDTH:   prdata = ApbDataW'(cfg_q.min_width);
      REG_MAX_WIDTH:   prdata = ApbDataW'(cfg_q.max_width);
      default:         prdata = '0;
    endcase
  end

  // ---- request unpacking
  assign in_item.kind         = kind_e'(s_axis_tuser);
  assign in_item.channel      = s_axis_tdata[ChanW-1:0];
  assign in_item.target_width = s_axis_tdata[ChanW+WidthW-1:ChanW];

  svp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // ---- slew, slot sequencing and result register
  svp_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .take_o        (take),
    .res_ready_i   (m_axis_tready),
    .res_valid_o   (m_axis_tvalid),
    .pulse_lines_o (pulse_lines),
    .frame_start_o (frame_start),
    .all_settled_o (all_settled)
  );

  // result packing: lines low, then frame start, then settled, zero fill
  assign m_axis_tdata = OutW'({all_settled, frame_start, pulse_lines});

endmodule

>>> rtl/core/svp_checker.sv
// ---------------------------------------------------------------------------
// svp_checker: port-level checks of the servo pulse sequencer
// watches the streaming ports and flags illegal pulse or handshake behavior
// ---------------------------------------------------------------------------
module svp_checker import svp_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels,
  localparam int unsigned OutW    = ((CHANNELS + 2 + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic [CHANNELS-1:0] lines;
  logic                fstart;

  assign lines  = m_axis_tdata[CHANNELS-1:0];
  assign fstart = m_axis_tdata[CHANNELS];

  // no result in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // at most one servo line is driven at a time
  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(lines))
    else $error("more than one pulse line high");

  // a frame always opens in the first channel's slot
  a_frame_first_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fstart) |-> ((lines & ~CHANNELS'(1)) == '0))
    else $error("frame start outside the first slot");

  // with no result waiting the request side is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request side blocked with empty result register");

  // a stalled result holds its value
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind servo_pulse_sequencer_with_slew svp_checker #(
  .CHANNELS (CHANNELS)
) u_svp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the servo pulse sequencer
// tick and target-write requests go in on the request stream; every result
// is checked field by field against an in-bench model of the frame, slot and
// slew behavior, across timing and clamp settings down to the extremes
// ---------------------------------------------------------------------------
module tb_top;
  import svp_pkg::*;

  localparam int unsigned NumCh     = DefChannels;
  localparam int unsigned OutW      = ((NumCh + 2 + 7) / 8) * 8;
  localparam int          NumPhases = 14;
  localparam int          PhaseReqs = 110;
  localparam int          IdleLimit = 1000;

  // result word: [5:0] pulse_lines, [6] frame_start, [7] all_settled
  typedef struct packed {
    logic             settled;
    logic             frame_start;
    logic [NumCh-1:0] lines;
  } pulse_res_t;

  // one directed request, with the result typed in where it is obvious
  typedef struct packed {
    kind_e             kind;
    logic [ChanW-1:0]  ch;
    logic [WidthW-1:0] tw;
    logic              typed;
    logic [NumCh-1:0]  lines;
    logic              fstart;
    logic              settled;
  } dir_row_t;

  // directed requests, all under the reset settings (frames of 40000 ticks)
  localparam int NumDir = 22;
  localparam dir_row_t DirTab [NumDir] = '{
    // first tick opens a frame, channel 0 high, everything settled
    '{KIND_TICK,       3'd0, 16'h0000, 1'b1, 6'h01, 1'b0 | 1'b1, 1'b1},
    // channel and width fields of a tick carry no meaning
    '{KIND_TICK,       3'd7, 16'hffff, 1'b1, 6'h01, 1'b0, 1'b1},
    // target above the maximum clamps to 5000
    '{KIND_SET_TARGET, 3'd0, 16'hffff, 1'b1, 6'h00, 1'b0, 1'b0},
    // out-of-range channels are dropped
    '{KIND_SET_TARGET, 3'd7, 16'h0000, 1'b1, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd6, 16'hffff, 1'b1, 6'h00, 1'b0, 1'b0},
    // target below the minimum clamps to 1000
    '{KIND_SET_TARGET, 3'd0, 16'h0000, 1'b1, 6'h00, 1'b0, 1'b0},
    // back to the current width, settled again
    '{KIND_SET_TARGET, 3'd0, 16'd3000, 1'b1, 6'h00, 1'b0, 1'b1},
    '{KIND_SET_TARGET, 3'd5, 16'd5000, 1'b1, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd5, 16'd3000, 1'b1, 6'h00, 1'b0, 1'b1},
    '{KIND_SET_TARGET, 3'd1, 16'd4999, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd2, 16'd1001, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd3, 16'h5555, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd4, 16'haaaa, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_TICK,       3'd0, 16'h0000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_TICK,       3'd5, 16'h1234, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd1, 16'd3000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd2, 16'd3000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd3, 16'd3000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd4, 16'd3000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_TICK,       3'd0, 16'h0000, 1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd0, 16'd999,  1'b0, 6'h00, 1'b0, 1'b0},
    '{KIND_SET_TARGET, 3'd0, 16'd3000, 1'b0, 6'h00, 1'b0, 1'b0}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block ports, all inputs at known values from time zero
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // [2:0] channel, [18:3] target_width
  logic                s_axis_tuser  = 1'b0; // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;        // [5:0] pulse_lines, [6] frame_start,
                                            // [7] all_settled
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  servo_pulse_sequencer_with_slew #(
    .CHANNELS (NumCh)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // model of the sequencer: its own copy of settings, widths and counters
  // ---------------------------------------------------------------------------
  cfg_t              mdl_cfg;
  logic [WidthW-1:0] cur_w [NumCh];
  logic [WidthW-1:0] tgt_w [NumCh];
  logic [WidthW-1:0] frame_cnt;
  logic [3:0]        slot_idx;   // NumCh means the idle gap after the slots
  logic [WidthW-1:0] slot_cnt;
  logic [WidthW-1:0] slot_width; // width of the slot's channel, taken at slot start

  pulse_res_t pending_pulses [$];
  int         fail_cnt = 0;
  bit         tx_burst = 1'b0;
  bit         rx_burst = 1'b0;

  initial begin
    mdl_cfg.slot_ticks  = RstSlotTicks;
    mdl_cfg.frame_ticks = RstFrameTicks;
    mdl_cfg.ramp_step   = RstRampStep;
    mdl_cfg.min_width   = RstMinWidth;
    mdl_cfg.max_width   = RstMaxWidth;
    for (int c = 0; c < NumCh; c++) begin
      cur_w[c] = RstWidth;
      tgt_w[c] = RstWidth;
    end
    frame_cnt  = '0;
    slot_idx   = '0;
    slot_cnt   = '0;
    slot_width = '0;
  end

  // apply one request to the model and return the pulse result it produces
  function automatic pulse_res_t next_pulse_result(input item_t req);
    pulse_res_t        res;
    logic [WidthW-1:0] tw;
    logic [WidthW-1:0] stp;
    logic [WidthW:0]   cnt_nx;
    logic [WidthW:0]   slot_len;
    logic [WidthW:0]   frame_len;
    res       = '0;
    stp       = WidthW'(mdl_cfg.ramp_step);
    // a zero length behaves as one tick
    slot_len  = (mdl_cfg.slot_ticks  == '0) ? 17'd1 : {1'b0, mdl_cfg.slot_ticks};
    frame_len = (mdl_cfg.frame_ticks == '0) ? 17'd1 : {1'b0, mdl_cfg.frame_ticks};
    if (req.kind == KIND_SET_TARGET) begin
      // min first, then max, so max wins when the limits cross
      if (req.channel < NumCh) begin
        tw = req.target_width;
        if (tw < mdl_cfg.min_width) tw = mdl_cfg.min_width;
        if (tw > mdl_cfg.max_width) tw = mdl_cfg.max_width;
        tgt_w[req.channel] = tw;
      end
    end else begin
      if (frame_cnt == '0) begin
        // frame start: slew every channel, landing exactly on its target
        res.frame_start = 1'b1;
        for (int c = 0; c < NumCh; c++) begin
          if (cur_w[c] < tgt_w[c]) begin
            cur_w[c] = ((tgt_w[c] - cur_w[c]) > stp) ? cur_w[c] + stp : tgt_w[c];
          end else if (cur_w[c] > tgt_w[c]) begin
            cur_w[c] = ((cur_w[c] - tgt_w[c]) > stp) ? cur_w[c] - stp : tgt_w[c];
          end
        end
        slot_idx   = '0;
        slot_cnt   = '0;
        slot_width = cur_w[0];
      end
      if (slot_idx < NumCh && slot_cnt < slot_width) res.lines[slot_idx] = 1'b1;
      if (slot_idx < NumCh) begin
        cnt_nx = {1'b0, slot_cnt} + 17'd1;
        if (cnt_nx >= slot_len) begin
          slot_idx   = slot_idx + 4'd1;
          slot_cnt   = '0;
          slot_width = (slot_idx < NumCh) ? cur_w[slot_idx] : '0;
        end else begin
          slot_cnt = cnt_nx[WidthW-1:0];
        end
      end
      cnt_nx    = {1'b0, frame_cnt} + 17'd1;
      frame_cnt = (cnt_nx >= frame_len) ? '0 : cnt_nx[WidthW-1:0];
    end
    res.settled = 1'b1;
    for (int c = 0; c < NumCh; c++) begin
      if (cur_w[c] != tgt_w[c]) res.settled = 1'b0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: random gap, then hold the request until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_req(input item_t req, input logic typed, input pulse_res_t typed_res);
    int         gap;
    pulse_res_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.kind;
    s_axis_tdata  <= {5'b0, req.target_width, req.channel};
    do @(posedge clk_i); while (!s_axis_tready);
    // accepted at this edge: the model runs even when the result is typed in
    pred = next_pulse_result(req);
    pending_pulses.push_back(typed ? typed_res : pred);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
  endtask

  function automatic cfg_t cfg_of(input int slot, input int frame, input int ramp,
                                  input int lo, input int hi);
    cfg_t c;
    c.slot_ticks  = WidthW'(slot);
    c.frame_ticks = WidthW'(frame);
    c.ramp_step   = RampW'(ramp);
    c.min_width   = WidthW'(lo);
    c.max_width   = WidthW'(hi);
    return c;
  endfunction

  // settings of each phase: a few fixed corners, the rest drawn at random
  function automatic cfg_t phase_cfg(input int ph);
    int s;
    case (ph)
      // widths snap to targets and may exceed the slot
      0: return cfg_of(4, 30, 4095, 0, 65535);
      // zero lengths act as one tick, no slew, crossed limits
      1: return cfg_of(0, 0, 0, 65535, 0);
      // longest slot and frame, every target forced to zero
      2: return cfg_of(65535, 65535, 4095, 0, 0);
      3: return cfg_of(1, 1, 1, 2, 5);
      // frame shorter than all slots together
      4: return cfg_of(3, 10, 2, 0, 6);
      default: begin
        s = $urandom_range(1, 9);
        return cfg_of(s, $urandom_range(1, 6 * s + 12),
                      ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 6),
                      $urandom_range(0, 2), $urandom_range(0, s + 3));
      end
    endcase
  endfunction

  // write all registers over the configuration port; block must be idle
  task automatic write_cfg(input cfg_t c);
    reg_idx_e idx;
    for (int i = 0; i < 5; i++) begin
      idx = reg_idx_e'(i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      case (idx)
        REG_SLOT_TICKS:  pwdata <= ApbDataW'(c.slot_ticks);
        REG_FRAME_TICKS: pwdata <= ApbDataW'(c.frame_ticks);
        REG_RAMP_STEP:   pwdata <= ApbDataW'(c.ramp_step);
        REG_MIN_WIDTH:   pwdata <= ApbDataW'(c.min_width);
        default:         pwdata <= ApbDataW'(c.max_width);
      endcase
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mdl_cfg = c;
  endtask

  // random request: mostly ticks, targets mostly near the slot length
  function automatic item_t rand_req();
    item_t req;
    int    span;
    span = int'(mdl_cfg.slot_ticks) + 4;
    if (span > 65535) span = 65535;
    req.kind    = ($urandom_range(0, 6) == 0) ? KIND_SET_TARGET : KIND_TICK;
    req.channel = ($urandom_range(0, 9) == 0) ? ChanW'($urandom_range(6, 7))
                                              : ChanW'($urandom_range(0, NumCh - 1));
    req.target_width = ($urandom_range(0, 3) == 0) ? WidthW'($urandom)
                                                   : WidthW'($urandom_range(0, span));
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall before each result, none in burst phases
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    pulse_res_t got;
    pulse_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pulse_res_t'(m_axis_tdata);
      if (pending_pulses.size() == 0) begin
        $error("result %h arrived with no request outstanding", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = pending_pulses.pop_front();
        if (got.lines !== want.lines) begin
          $error("pulse_lines: expected %b, got %b", want.lines, got.lines);
          fail_cnt++;
        end
        if (got.frame_start !== want.frame_start) begin
          $error("frame_start: expected %b, got %b", want.frame_start, got.frame_start);
          fail_cnt++;
        end
        if (got.settled !== want.settled) begin
          $error("all_settled: expected %b, got %b", want.settled, got.settled);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: nothing moving on any port for too long ends the run
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $error("no request or result moved for %0d cycles", IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    pulse_res_t typed_res;
    item_t      req;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests under the reset settings
    for (int i = 0; i < NumDir; i++) begin
      req.kind          = DirTab[i].kind;
      req.channel       = DirTab[i].ch;
      req.target_width  = DirTab[i].tw;
      typed_res.lines       = DirTab[i].lines;
      typed_res.frame_start = DirTab[i].fstart;
      typed_res.settled     = DirTab[i].settled;
      send_req(req, DirTab[i].typed, typed_res);
    end

    // random phases; each boundary drains all results before reconfiguring,
    // so counters carry over and a shrunk slot or frame ends on the next tick
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_cfg(phase_cfg(ph));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      repeat (PhaseReqs) send_req(rand_req(), 1'b0, '0);
    end

    drain_results();
    // let any stray result show up before the verdict
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_pulses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/svp_pkg.sv
rtl/core/svp_in_stage.sv
rtl/core/svp_engine.sv
rtl/core/servo_pulse_sequencer_with_slew.sv
rtl/core/svp_checker.sv
tb/tb_top.sv
